FILE: rtl/core/bf3_pkg.sv
// ----------------------------------------------------------------------------
// bf3_pkg: shared types and constants of the 3x3 box filter
// Field widths, register indexes, opcodes and the divide-by-nine helper.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIXEL_W   = 8;
  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int COL_W     = 10;  // sum of three pixels
  localparam int SUM_W     = 12;  // sum of nine pixels

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [IMG_W_W-1:0] RESET_WIDTH  = 11'd1024;
  localparam logic [IMG_H_W-1:0] RESET_HEIGHT = 16'd768;

  // floor(s / 9) == (s * 1821) >> 14 for every s below 2304
  localparam int DIV9_MUL_W = 11;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 11'd1821;
  localparam int DIV9_SHIFT = 14;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef struct packed {
    logic valid;
    logic is_flush;
    logic row0;
    logic col_last;
    logic x_first;
    logic x_last;
  } s1_ctl_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] mean_pixel;
    logic               run_last;
    logic               frame_end;
  } res_t;

  function automatic logic [PIXEL_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+DIV9_MUL_W-1:0] prod;
    prod = SUM_W'(s) * DIV9_MUL;
    return prod[DIV9_SHIFT +: PIXEL_W];
  endfunction

endpackage

FILE: rtl/core/bf3_line_store.sv
// ----------------------------------------------------------------------------
// bf3_line_store: one row of pixels
// Single write port, two registered read ports.
// ----------------------------------------------------------------------------
module bf3_line_store #(
  parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [bf3_pkg::PIXEL_W-1:0] wdata,
  input  logic [AW-1:0]               ra_addr,
  input  logic [AW-1:0]               rb_addr,
  output logic [bf3_pkg::PIXEL_W-1:0] ra_data,
  output logic [bf3_pkg::PIXEL_W-1:0] rb_data
);

  logic [bf3_pkg::PIXEL_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

FILE: rtl/core/bf3_ctrl.sv
// ----------------------------------------------------------------------------
// bf3_ctrl: configuration, position counters and item decode
// Clamps the counters, issues line store reads and loads the work stage.
// ----------------------------------------------------------------------------
module bf3_ctrl #(
  parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bf3_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_fire,
  input  logic                          in_op,
  input  logic [bf3_pkg::PIXEL_W-1:0]   in_px,
  output logic [AW-1:0]                 rd_a_addr,
  output logic [AW-1:0]                 rd_b_addr,
  output bf3_pkg::s1_ctl_t              s1_ctl,
  output logic [AW-1:0]                 s1_addr,
  output logic [AW-1:0]                 s1_baddr,
  output logic [bf3_pkg::PIXEL_W-1:0]   s1_px
);

  localparam int UW = (bf3_pkg::IMG_W_W > AW + 1) ? bf3_pkg::IMG_W_W : AW + 1;

  logic [bf3_pkg::IMG_W_W-1:0] image_width_r;
  logic [bf3_pkg::IMG_H_W-1:0] image_height_r;
  logic [AW-1:0]               column_count_r, column_count_nxt;
  logic [bf3_pkg::IMG_H_W-1:0] row_count_r, row_count_nxt;
  logic [AW-1:0]               flush_count_r, flush_count_nxt;
  bf3_pkg::s1_ctl_t            s1_ctl_r, s1_ctl_nxt;
  logic [AW-1:0]               s1_addr_r;
  logic [AW-1:0]               s1_baddr_r;
  logic [bf3_pkg::PIXEL_W-1:0] s1_px_r;

  logic [UW-1:0]               w_ext;
  logic [UW-1:0]               w_used;
  logic [UW-1:0]               wm1_full;
  logic [AW-1:0]               wm1;
  logic [bf3_pkg::IMG_H_W-1:0] h_used;
  logic                        frame_full;
  logic [AW-1:0]               col;
  logic [AW-1:0]               fx;
  logic                        col_last;
  logic                        x_last;
  logic                        x_first;
  logic                        pix_go;
  logic                        flush_go;

  always_comb begin
    w_ext = UW'(image_width_r);
    if (w_ext == '0) begin
      w_used = UW'(1);
    end else if (w_ext > UW'(MAX_WIDTH)) begin
      w_used = UW'(MAX_WIDTH);
    end else begin
      w_used = w_ext;
    end
    wm1_full = w_used - UW'(1);
    wm1      = wm1_full[AW-1:0];
  end

  assign h_used     = (image_height_r == '0) ? bf3_pkg::IMG_H_W'(1) : image_height_r;
  assign frame_full = (row_count_r >= h_used);
  assign col        = (column_count_r > wm1) ? wm1 : column_count_r;
  assign fx         = (flush_count_r > wm1) ? wm1 : flush_count_r;
  assign col_last   = (col == wm1);
  assign x_last     = (fx == wm1);
  assign x_first    = (fx == '0);
  assign pix_go     = in_fire && (in_op == bf3_pkg::OP_PIXEL) && !frame_full;
  assign flush_go   = in_fire && (in_op == bf3_pkg::OP_FLUSH) && frame_full;

  always_comb begin
    if (in_op == bf3_pkg::OP_FLUSH) begin
      rd_a_addr = fx;
      if (!x_last) begin
        rd_b_addr = fx + AW'(1);
      end else if (x_first) begin
        rd_b_addr = fx;
      end else begin
        rd_b_addr = fx - AW'(1);
      end
    end else begin
      rd_a_addr = col;
      rd_b_addr = col;
    end
  end

  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    flush_count_nxt  = flush_count_r;
    if (pix_go) begin
      if (col_last) begin
        column_count_nxt = '0;
        row_count_nxt    = row_count_r + bf3_pkg::IMG_H_W'(1);
      end else begin
        column_count_nxt = col + AW'(1);
      end
    end else if (flush_go) begin
      if (x_last) begin
        flush_count_nxt  = '0;
        row_count_nxt    = '0;
        column_count_nxt = '0;
      end else begin
        flush_count_nxt = fx + AW'(1);
      end
    end
  end

  always_comb begin
    s1_ctl_nxt.valid    = pix_go || flush_go;
    s1_ctl_nxt.is_flush = flush_go;
    s1_ctl_nxt.row0     = (row_count_r == '0);
    s1_ctl_nxt.col_last = col_last;
    s1_ctl_nxt.x_first  = x_first;
    s1_ctl_nxt.x_last   = x_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= bf3_pkg::RESET_WIDTH;
      image_height_r <= bf3_pkg::RESET_HEIGHT;
      column_count_r <= '0;
      row_count_r    <= '0;
      flush_count_r  <= '0;
      s1_ctl_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bf3_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[bf3_pkg::IMG_W_W-1:0];
          bf3_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[bf3_pkg::IMG_H_W-1:0];
          default: ;
        endcase
      end
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
      flush_count_r  <= flush_count_nxt;
      s1_ctl_r       <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r  <= (in_op == bf3_pkg::OP_FLUSH) ? fx : col;
    s1_baddr_r <= rd_b_addr;
    s1_px_r    <= in_px;
  end

  assign s1_ctl   = s1_ctl_r;
  assign s1_addr  = s1_addr_r;
  assign s1_baddr = s1_baddr_r;
  assign s1_px    = s1_px_r;

endmodule

FILE: rtl/core/bf3_datapath.sv
// ----------------------------------------------------------------------------
// bf3_datapath: window update, line store write-back and result math
// Forwards the last write, keeps three column sums and a flush column cache.
// ----------------------------------------------------------------------------
module bf3_datapath #(
  parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bf3_pkg::s1_ctl_t            s1_ctl,
  input  logic [AW-1:0]               s1_addr,
  input  logic [AW-1:0]               s1_baddr,
  input  logic [bf3_pkg::PIXEL_W-1:0] s1_px,
  input  logic [bf3_pkg::PIXEL_W-1:0] ua_q,
  input  logic [bf3_pkg::PIXEL_W-1:0] ub_q,
  input  logic [bf3_pkg::PIXEL_W-1:0] ma_q,
  input  logic [bf3_pkg::PIXEL_W-1:0] mb_q,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [bf3_pkg::PIXEL_W-1:0] up_wdata,
  output logic [bf3_pkg::PIXEL_W-1:0] mid_wdata,
  output bf3_pkg::res_t               res_a,
  output bf3_pkg::res_t               res_b,
  output logic [1:0]                  n_push
);

  localparam int CW = bf3_pkg::COL_W;
  localparam int SW = bf3_pkg::SUM_W;

  logic                        fwd_we_r;
  logic [AW-1:0]               fwd_addr_r;
  logic [bf3_pkg::PIXEL_W-1:0] fwd_u_r;
  logic [bf3_pkg::PIXEL_W-1:0] fwd_m_r;
  logic [AW-1:0]               cache_addr_r, cache_addr_nxt;
  logic [CW-1:0]               cache_v_r, cache_v_nxt;
  logic [CW-1:0]               cs0_r, cs1_r, cs2_r;
  logic [CW-1:0]               cs0_nxt, cs1_nxt, cs2_nxt;

  logic [bf3_pkg::PIXEL_W-1:0] ua_eff, ma_eff, ub_eff, mb_eff;
  logic [CW-1:0]               new_col;
  logic [CW-1:0]               va, vb;
  logic                        pix_live;
  logic                        has_left;
  logic [SW-1:0]               sum_a, sum_b, sum_f;
  bf3_pkg::res_t               pix_a, pix_b, fl_res;

  always_comb begin
    if (fwd_we_r && (fwd_addr_r == s1_addr)) begin
      ua_eff = fwd_u_r;
      ma_eff = fwd_m_r;
    end else begin
      ua_eff = ua_q;
      ma_eff = ma_q;
    end
    if (fwd_we_r && (fwd_addr_r == s1_baddr)) begin
      ub_eff = fwd_u_r;
      mb_eff = fwd_m_r;
    end else begin
      ub_eff = ub_q;
      mb_eff = mb_q;
    end
  end

  assign mem_we    = s1_ctl.valid && !s1_ctl.is_flush;
  assign mem_waddr = s1_addr;
  assign up_wdata  = s1_ctl.row0 ? s1_px : ma_eff;
  assign mid_wdata = s1_px;

  assign pix_live = mem_we && !s1_ctl.row0;
  assign has_left = (s1_addr != '0);

  assign new_col = CW'(ua_eff) + CW'(ma_eff) + CW'(s1_px);
  assign va      = CW'(ua_eff) + (CW'(ma_eff) << 1);
  assign vb      = CW'(ub_eff) + (CW'(mb_eff) << 1);

  always_comb begin
    cs0_nxt = cs0_r;
    cs1_nxt = cs1_r;
    cs2_nxt = cs2_r;
    if (pix_live) begin
      if (has_left) begin
        cs0_nxt = cs1_r;
        cs1_nxt = cs2_r;
      end else begin
        cs0_nxt = new_col;
        cs1_nxt = new_col;
      end
      cs2_nxt = new_col;
    end
  end

  assign sum_a = SW'(cs0_nxt) + SW'(cs1_nxt) + SW'(cs2_nxt);
  assign sum_b = SW'(cs1_nxt) + (SW'(cs2_nxt) << 1);

  always_comb begin
    if (s1_ctl.x_first) begin
      sum_f = (SW'(va) << 1) + SW'(vb);
    end else if (s1_ctl.x_last) begin
      sum_f = SW'(vb) + (SW'(va) << 1);
    end else begin
      sum_f = SW'(cache_v_r) + SW'(va) + SW'(vb);
    end
  end

  always_comb begin
    pix_a.mean_pixel  = bf3_pkg::div9(sum_a);
    pix_a.run_last    = !s1_ctl.col_last;
    pix_a.frame_end   = 1'b0;
    pix_b.mean_pixel  = bf3_pkg::div9(sum_b);
    pix_b.run_last    = 1'b1;
    pix_b.frame_end   = 1'b0;
    fl_res.mean_pixel = bf3_pkg::div9(sum_f);
    fl_res.run_last   = 1'b1;
    fl_res.frame_end  = s1_ctl.x_last;
  end

  always_comb begin
    res_b = pix_b;
    if (s1_ctl.is_flush) begin
      res_a = fl_res;
    end else if (has_left) begin
      res_a = pix_a;
    end else begin
      res_a = pix_b;
    end
    if (s1_ctl.valid && s1_ctl.is_flush) begin
      n_push = 2'd1;
    end else if (pix_live) begin
      n_push = 2'(has_left) + 2'(s1_ctl.col_last);
    end else begin
      n_push = 2'd0;
    end
  end

  // keep the cached column weight coherent with line store writes
  always_comb begin
    cache_addr_nxt = cache_addr_r;
    cache_v_nxt    = cache_v_r;
    if (s1_ctl.valid && s1_ctl.is_flush) begin
      cache_addr_nxt = s1_addr;
      cache_v_nxt    = va;
    end else if (mem_we && (s1_addr == cache_addr_r)) begin
      cache_v_nxt = CW'(up_wdata) + (CW'(mid_wdata) << 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_we_r <= 1'b0;
      cs0_r    <= '0;
      cs1_r    <= '0;
      cs2_r    <= '0;
    end else begin
      fwd_we_r <= mem_we;
      cs0_r    <= cs0_nxt;
      cs1_r    <= cs1_nxt;
      cs2_r    <= cs2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r   <= mem_waddr;
    fwd_u_r      <= up_wdata;
    fwd_m_r      <= mid_wdata;
    cache_addr_r <= cache_addr_nxt;
    cache_v_r    <= cache_v_nxt;
  end

endmodule

FILE: rtl/core/bf3_out_fifo.sv
// ----------------------------------------------------------------------------
// bf3_out_fifo: result queue
// Takes up to two results per cycle, hands out one item per cycle when popped.
// ----------------------------------------------------------------------------
module bf3_out_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bf3_pkg::res_t                 push_a,
  input  bf3_pkg::res_t                 push_b,
  input  logic [1:0]                    n_push,
  input  logic                          pop,
  output bf3_pkg::res_t                 head,
  output logic                          not_empty,
  output logic [bf3_pkg::OUT_CNT_W-1:0] count
);

  bf3_pkg::res_t                 slot_r [bf3_pkg::OUT_DEPTH];
  logic [bf3_pkg::OUT_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bf3_pkg::OUT_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bf3_pkg::OUT_CNT_W-1:0] count_r, count_nxt;
  logic [bf3_pkg::OUT_PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + bf3_pkg::OUT_PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + bf3_pkg::OUT_PTR_W'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + bf3_pkg::OUT_PTR_W'(pop);
  assign count_nxt  = count_r + bf3_pkg::OUT_CNT_W'(n_push) - bf3_pkg::OUT_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      slot_r[wr_ptr_r] <= push_a;
    end
    if (n_push == 2'd2) begin
      slot_r[wr_ptr_p1] <= push_b;
    end
  end

  assign head      = slot_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

FILE: rtl/core/box_filter_3x3_edge_replicate_core.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_replicate_core: streaming 3x3 mean filter
// Clamp-to-edge borders, two line stores, flush items drain the last row.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output keeps up. A result passes
// the work stage and a four-entry result queue. The pixel that closes a row
// (from the second row on, width above one) yields two results; since the input
// only opens while the queue keeps room for two more results, the input stalls
// while such a pixel is in the work stage whenever an earlier result is still
// queued, as in a steady stream. Every other item yields at most one result
// and sustains one item per cycle while the output keeps up. The line stores
// need no clearing after reset, so the block is ready as soon as reset ends.
module box_filter_3x3_edge_replicate_core #(
  parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bf3_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] pixel
  input  logic [0:0]                    in_tuser,   // [0] opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] mean_pixel
  output logic                          out_tlast,  // run_last
  output logic [0:0]                    out_tuser   // [0] frame_end
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic                          in_fire;
  logic [AW-1:0]                 rd_a_addr, rd_b_addr;
  bf3_pkg::s1_ctl_t              s1_ctl;
  logic [AW-1:0]                 s1_addr, s1_baddr;
  logic [bf3_pkg::PIXEL_W-1:0]   s1_px;
  logic [bf3_pkg::PIXEL_W-1:0]   ua_q, ub_q, ma_q, mb_q;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [bf3_pkg::PIXEL_W-1:0]   up_wdata, mid_wdata;
  bf3_pkg::res_t                 res_a, res_b, head;
  logic [1:0]                    n_push;
  logic                          pop;
  logic [bf3_pkg::OUT_CNT_W-1:0] q_count;
  logic [bf3_pkg::OUT_CNT_W-1:0] q_commit;

  assign q_commit  = q_count + bf3_pkg::OUT_CNT_W'(n_push);
  assign in_tready = (q_commit <= bf3_pkg::OUT_CNT_W'(bf3_pkg::OUT_DEPTH - 2));
  assign in_fire   = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;

  bf3_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_op     (in_tuser[0]),
    .in_px     (in_tdata),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .s1_ctl    (s1_ctl),
    .s1_addr   (s1_addr),
    .s1_baddr  (s1_baddr),
    .s1_px     (s1_px)
  );

  bf3_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (up_wdata),
    .ra_addr (rd_a_addr),
    .rb_addr (rd_b_addr),
    .ra_data (ua_q),
    .rb_data (ub_q)
  );

  bf3_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_middle (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mid_wdata),
    .ra_addr (rd_a_addr),
    .rb_addr (rd_b_addr),
    .ra_data (ma_q),
    .rb_data (mb_q)
  );

  bf3_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_ctl    (s1_ctl),
    .s1_addr   (s1_addr),
    .s1_baddr  (s1_baddr),
    .s1_px     (s1_px),
    .ua_q      (ua_q),
    .ub_q      (ub_q),
    .ma_q      (ma_q),
    .mb_q      (mb_q),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .up_wdata  (up_wdata),
    .mid_wdata (mid_wdata),
    .res_a     (res_a),
    .res_b     (res_b),
    .n_push    (n_push)
  );

  bf3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (res_a),
    .push_b    (res_b),
    .n_push    (n_push),
    .pop       (pop),
    .head      (head),
    .not_empty (out_tvalid),
    .count     (q_count)
  );

  assign out_tdata    = head.mean_pixel;
  assign out_tlast    = head.run_last;
  assign out_tuser[0] = head.frame_end;

  // result queue never overruns
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_commit <= bf3_pkg::OUT_CNT_W'(bf3_pkg::OUT_DEPTH))
    else $error("result queue overrun");

  // work stage only holds an item that was accepted the cycle before
  a_stage_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ctl.valid |-> $past(in_tvalid && in_tready))
    else $error("work stage loaded without an accepted item");

  // two results only from a pixel closing a row
  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push == 2'd2) |-> (s1_ctl.col_last && !s1_ctl.is_flush && !s1_ctl.row0))
    else $error("two results from an item that does not close a row");

  // frame end marks the last result of its item
  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("frame end without run last");

endmodule

FILE: sim/tb_box_filter_3x3_edge_replicate_core.sv
// ----------------------------------------------------------------------------
// tb_box_filter_3x3_edge_replicate_core: self-checking bench of the 3x3 mean
// Drives frames of grey pixels and flush items over the input stream. It
// predicts the filtered pixels with a local copy of the line stores and the
// window, or takes them from the table for typed rows, and checks each result
// in order. A directed table covers reset values, register extremes, ignored
// items and mid-frame register changes. Random frames of small sizes follow.
// ----------------------------------------------------------------------------
module tb_box_filter_3x3_edge_replicate_core;

  localparam int MAX_W        = bf3_pkg::MAX_WIDTH_DEF;
  localparam int DIR_ROWS     = 44;
  localparam int RANDOM_ITEMS = 1730;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 8;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_SETTLE} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic          arg;
    logic [15:0]   val;
    logic          typed;
    logic [1:0]    tn;
    bf3_pkg::res_t res;
  } stim_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [bf3_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bf3_pkg::CFG_W-1:0]     cfg_wdata;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [7:0]                    in_tdata;   // [7:0] pixel
  logic [0:0]                    in_tuser;   // [0] opcode
  logic                          out_tvalid;
  logic                          out_tready;
  logic [7:0]                    out_tdata;  // [7:0] mean_pixel
  logic                          out_tlast;  // run_last
  logic [0:0]                    out_tuser;  // [0] frame_end

  box_filter_3x3_edge_replicate_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  logic [7:0]   up_row [MAX_W];
  logic [7:0]   mid_row [MAX_W];
  logic [7:0]   win [9];
  int unsigned  col_q;
  int unsigned  row_q;
  int unsigned  flush_q;
  logic [10:0]  width_reg;
  logic [15:0]  height_reg;

  bf3_pkg::res_t filtered_q [$];
  bf3_pkg::res_t want_res;
  stim_row_t     dir_rows [DIR_ROWS];
  int            errors;
  int            sent_items;
  bit            calm;

  always #2 clk = ~clk;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic int unsigned col_sum(input int unsigned j);
    return win[3*j] + win[3*j+1] + win[3*j+2];
  endfunction

  function automatic logic [7:0] mean9(input int unsigned s);
    return 8'(s / 9);
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic clear_filter();
    int k;
    for (k = 0; k < MAX_W; k++) begin
      up_row[k] = '0;
      mid_row[k] = '0;
    end
    for (k = 0; k < 9; k++) win[k] = '0;
    col_q = 0;
    row_q = 0;
    flush_q = 0;
    width_reg = bf3_pkg::RESET_WIDTH;
    height_reg = bf3_pkg::RESET_HEIGHT;
  endtask

  task automatic filter_step(input logic op, input logic [7:0] px, output int n,
                             output bf3_pkg::res_t r0, output bf3_pkg::res_t r1);
    int unsigned w, h, c, x, lo, hi, s;
    logic [7:0]  u, m;
    int          k;
    n = 0;
    r0 = '0;
    r1 = '0;
    w = eff_width();
    h = eff_height();
    if (op == bf3_pkg::OP_PIXEL) begin
      if (row_q < h) begin
        c = (col_q > w - 1) ? w - 1 : col_q;
        if (row_q == 0) begin
          up_row[c] = px;
          mid_row[c] = px;
        end else begin
          u = up_row[c];
          m = mid_row[c];
          up_row[c] = m;
          mid_row[c] = px;
          if (c == 0) begin
            for (k = 0; k < 3; k++) begin
              win[3*k] = u;
              win[3*k+1] = m;
              win[3*k+2] = px;
            end
          end else begin
            for (k = 0; k < 6; k++) win[k] = win[k+3];
            win[6] = u;
            win[7] = m;
            win[8] = px;
          end
          if (c >= 1) begin
            s = col_sum(0) + col_sum(1) + col_sum(2);
            r0 = '{mean9(s), (c != w - 1), 1'b0};
            n = 1;
          end
          if (c == w - 1) begin
            s = col_sum(1) + 2 * col_sum(2);
            if (n == 0) r0 = '{mean9(s), 1'b1, 1'b0};
            else r1 = '{mean9(s), 1'b1, 1'b0};
            n++;
          end
        end
        if (c == w - 1) begin
          col_q = 0;
          row_q++;
        end else begin
          col_q = c + 1;
        end
      end
    end else if (row_q >= h) begin
      x = (flush_q > w - 1) ? w - 1 : flush_q;
      lo = (x == 0) ? 0 : x - 1;
      hi = (x + 1 < w) ? x + 1 : w - 1;
      s = up_row[lo] + 2 * mid_row[lo] + up_row[x] + 2 * mid_row[x]
        + up_row[hi] + 2 * mid_row[hi];
      r0 = '{mean9(s), 1'b1, (x == w - 1)};
      n = 1;
      if (x == w - 1) begin
        flush_q = 0;
        row_q = 0;
        col_q = 0;
      end else begin
        flush_q = x + 1;
      end
    end
  endtask

  task automatic send_item(input logic op, input logic [7:0] px, input logic typed,
                           input logic [1:0] tn, input bf3_pkg::res_t tres);
    int            n;
    bf3_pkg::res_t r0, r1;
    while (!calm && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    filter_step(op, px, n, r0, r1);
    if (typed) begin
      if (tn != 0) filtered_q.push_back(tres);
    end else begin
      if (n > 0) filtered_q.push_back(r0);
      if (n > 1) filtered_q.push_back(r1);
    end
    sent_items++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [bf3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == bf3_pkg::REG_IMAGE_WIDTH) width_reg = val[10:0];
    else height_reg = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    int guard;
    in_tvalid <= 1'b0;
    guard = 0;
    while (filtered_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    if (filtered_q.size() != 0) begin
      $error("%0d expected results never arrived", filtered_q.size());
      errors++;
      filtered_q.delete();
    end
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic run_frame(input logic [15:0] wval, input logic [15:0] hval,
                           input bit noisy);
    int unsigned w, h, rows, cut, y, xx, k;
    settle();
    write_reg(bf3_pkg::REG_IMAGE_WIDTH, wval);
    write_reg(bf3_pkg::REG_IMAGE_HEIGHT, hval);
    w = eff_width();
    h = eff_height();
    cut = 0;
    if (noisy && h > 1 && $urandom_range(5) == 0) cut = $urandom_range(1, h - 1);
    rows = (cut != 0) ? cut : h;
    for (y = 0; y < rows; y++) begin
      for (xx = 0; xx < w; xx++) begin
        if ($urandom_range(99) == 0) settle();
        if (noisy && $urandom_range(49) == 0)
          send_item(bf3_pkg::OP_FLUSH, rand_pixel(), 1'b0, 2'd0, '0);
        send_item(bf3_pkg::OP_PIXEL, rand_pixel(), 1'b0, 2'd0, '0);
      end
    end
    if (cut != 0) begin
      settle();
      write_reg(bf3_pkg::REG_IMAGE_HEIGHT, 16'(cut));
    end
    if (noisy && $urandom_range(3) == 0) begin
      for (k = $urandom_range(1, 3); k > 0; k--)
        send_item(bf3_pkg::OP_PIXEL, rand_pixel(), 1'b0, 2'd0, '0);
    end
    for (xx = 0; xx < w; xx++)
      send_item(bf3_pkg::OP_FLUSH, rand_pixel(), 1'b0, 2'd0, '0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (filtered_q.size() == 0) begin
        $error("unexpected result: mean_pixel %0d run_last %0d frame_end %0d",
               out_tdata, out_tlast, out_tuser[0]);
        errors++;
      end else begin
        want_res = filtered_q.pop_front();
        if (out_tdata !== want_res.mean_pixel) begin
          $error("mean_pixel expected %0d actual %0d", want_res.mean_pixel, out_tdata);
          errors++;
        end
        if (out_tlast !== want_res.run_last) begin
          $error("run_last expected %0d actual %0d", want_res.run_last, out_tlast);
          errors++;
        end
        if (out_tuser[0] !== want_res.frame_end) begin
          $error("frame_end expected %0d actual %0d", want_res.frame_end, out_tuser[0]);
          errors++;
        end
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= calm || ($urandom_range(99) >= 21);
    end
  end

  initial begin
    #4000000;
    $display("box_filter_3x3_edge_replicate_core test failed");
    $finish;
  end

  initial begin
    int          i;
    int          base;
    int          frame_no;
    int unsigned wv;
    int unsigned hv;
    stim_row_t   rw;
    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    calm       = 1'b0;
    errors     = 0;
    sent_items = 0;
    clear_filter();

    dir_rows[0]  = '{ROW_ITEM,   bf3_pkg::OP_FLUSH,         16'd0,    1'b1, 2'd0, '0};
    dir_rows[1]  = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'h5A,   1'b1, 2'd0, '0};
    dir_rows[2]  = '{ROW_SETTLE, 1'b0,                      16'd0,    1'b0, 2'd0, '0};
    dir_rows[3]  = '{ROW_CFG,    bf3_pkg::REG_IMAGE_WIDTH,  16'd1,    1'b0, 2'd0, '0};
    dir_rows[4]  = '{ROW_CFG,    bf3_pkg::REG_IMAGE_HEIGHT, 16'd1,    1'b0, 2'd0, '0};
    dir_rows[5]  = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd255,  1'b1, 2'd0, '0};
    dir_rows[6]  = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd0,    1'b1, 2'd0, '0};
    dir_rows[7]  = '{ROW_ITEM,   bf3_pkg::OP_FLUSH,         16'd0,    1'b1, 2'd1,
                     '{8'd255, 1'b1, 1'b1}};
    dir_rows[8]  = '{ROW_SETTLE, 1'b0,                      16'd0,    1'b0, 2'd0, '0};
    dir_rows[9]  = '{ROW_CFG,    bf3_pkg::REG_IMAGE_WIDTH,  16'd0,    1'b0, 2'd0, '0};
    dir_rows[10] = '{ROW_CFG,    bf3_pkg::REG_IMAGE_HEIGHT, 16'd0,    1'b0, 2'd0, '0};
    dir_rows[11] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd0,    1'b1, 2'd0, '0};
    dir_rows[12] = '{ROW_ITEM,   bf3_pkg::OP_FLUSH,         16'd255,  1'b1, 2'd1,
                     '{8'd0, 1'b1, 1'b1}};
    dir_rows[13] = '{ROW_SETTLE, 1'b0,                      16'd0,    1'b0, 2'd0, '0};
    dir_rows[14] = '{ROW_CFG,    bf3_pkg::REG_IMAGE_WIDTH,  16'd2,    1'b0, 2'd0, '0};
    dir_rows[15] = '{ROW_CFG,    bf3_pkg::REG_IMAGE_HEIGHT, 16'd2,    1'b0, 2'd0, '0};
    dir_rows[16] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd255,  1'b1, 2'd0, '0};
    dir_rows[17] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd255,  1'b1, 2'd0, '0};
    dir_rows[18] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd255,  1'b1, 2'd0, '0};
    dir_rows[19] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd255,  1'b0, 2'd0, '0};
    dir_rows[20] = '{ROW_ITEM,   bf3_pkg::OP_FLUSH,         16'd0,    1'b1, 2'd1,
                     '{8'd255, 1'b1, 1'b0}};
    dir_rows[21] = '{ROW_ITEM,   bf3_pkg::OP_FLUSH,         16'd0,    1'b1, 2'd1,
                     '{8'd255, 1'b1, 1'b1}};
    dir_rows[22] = '{ROW_SETTLE, 1'b0,                      16'd0,    1'b0, 2'd0, '0};
    dir_rows[23] = '{ROW_CFG,    bf3_pkg::REG_IMAGE_WIDTH,  16'd1,    1'b0, 2'd0, '0};
    dir_rows[24] = '{ROW_CFG,    bf3_pkg::REG_IMAGE_HEIGHT, 16'd3,    1'b0, 2'd0, '0};
    dir_rows[25] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd0,    1'b1, 2'd0, '0};
    dir_rows[26] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd255,  1'b0, 2'd0, '0};
    dir_rows[27] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd0,    1'b0, 2'd0, '0};
    dir_rows[28] = '{ROW_ITEM,   bf3_pkg::OP_FLUSH,         16'd0,    1'b0, 2'd0, '0};
    dir_rows[29] = '{ROW_SETTLE, 1'b0,                      16'd0,    1'b0, 2'd0, '0};
    dir_rows[30] = '{ROW_CFG,    bf3_pkg::REG_IMAGE_WIDTH,  16'hF803, 1'b0, 2'd0, '0};
    dir_rows[31] = '{ROW_CFG,    bf3_pkg::REG_IMAGE_HEIGHT, 16'hFFFF, 1'b0, 2'd0, '0};
    dir_rows[32] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd0,    1'b0, 2'd0, '0};
    dir_rows[33] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd255,  1'b0, 2'd0, '0};
    dir_rows[34] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd17,   1'b0, 2'd0, '0};
    dir_rows[35] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd255,  1'b0, 2'd0, '0};
    dir_rows[36] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd0,    1'b0, 2'd0, '0};
    dir_rows[37] = '{ROW_ITEM,   bf3_pkg::OP_PIXEL,         16'd128,  1'b0, 2'd0, '0};
    dir_rows[38] = '{ROW_SETTLE, 1'b0,                      16'd0,    1'b0, 2'd0, '0};
    dir_rows[39] = '{ROW_CFG,    bf3_pkg::REG_IMAGE_HEIGHT, 16'd2,    1'b0, 2'd0, '0};
    dir_rows[40] = '{ROW_ITEM,   bf3_pkg::OP_FLUSH,         16'd0,    1'b0, 2'd0, '0};
    dir_rows[41] = '{ROW_ITEM,   bf3_pkg::OP_FLUSH,         16'd0,    1'b0, 2'd0, '0};
    dir_rows[42] = '{ROW_ITEM,   bf3_pkg::OP_FLUSH,         16'd0,    1'b0, 2'd0, '0};
    dir_rows[43] = '{ROW_SETTLE, 1'b0,                      16'd0,    1'b0, 2'd0, '0};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      rw = dir_rows[i];
      case (rw.kind)
        ROW_ITEM: send_item(rw.arg, rw.val[7:0], rw.typed, rw.tn, rw.res);
        ROW_CFG:  write_reg(rw.arg, rw.val);
        default:  settle();
      endcase
    end

    base = sent_items;
    frame_no = 0;
    while (sent_items - base < RANDOM_ITEMS) begin
      calm = (frame_no >= 12 && frame_no < 20);
      case ($urandom_range(9))
        0:       wv = 0;
        1:       wv = 1;
        2, 3:    wv = $urandom_range(2, 4);
        8:       wv = $urandom_range(17, 64);
        default: wv = $urandom_range(5, 16);
      endcase
      hv = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
      run_frame({5'($urandom), 11'(wv)}, 16'(hv), ($urandom_range(3) != 0));
      frame_no++;
    end
    calm = 1'b0;

    settle();
    if (errors == 0) begin
      $display("box_filter_3x3_edge_replicate_core test passed");
    end else begin
      $display("box_filter_3x3_edge_replicate_core test failed");
    end
    $finish;
  end

endmodule
